>>> design/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg: shared types and helpers for the palette nearest-color matcher
// Function and status codes, the cell-to-cell bus type and the RGB distance.
// ----------------------------------------------------------------------------
package pnc_pkg;

   localparam int PNC_MAX_ENTRIES = 16;

   localparam logic [1:0] FUNC_ADD    = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NOMATCH = 2'd3;

   // 3 * 255^2 fits in 18 bits
   localparam int DIST_W = 18;

   typedef struct packed {
      logic              active;
      logic [1:0]        func;
      logic [23:0]       color;
      logic              found;
      logic              have;
      logic [DIST_W-1:0] best_dist;
      logic [23:0]       best_color;
   } cell_bus_type;

   function automatic logic [15:0] gap_sq(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return 16'(d) * 16'(d);
   endfunction

   function automatic logic [DIST_W-1:0] color_dist_sq(input logic [23:0] a,
                                                       input logic [23:0] b);
      return DIST_W'(gap_sq(a[23:16], b[23:16]))
           + DIST_W'(gap_sq(a[15:8], b[15:8]))
           + DIST_W'(gap_sq(a[7:0], b[7:0]));
   endfunction

endpackage

>>> design/pnc_if.sv
// ----------------------------------------------------------------------------
// pnc_req_if / pnc_rsp_if: request and response channels
// Valid/ready handshake with the request or response payload.
// ----------------------------------------------------------------------------
interface pnc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, func, red, green, blue, input ready);
   modport sink   (input valid, func, red, green, blue, output ready);
endinterface

interface pnc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] match_red;
   logic [7:0] match_green;
   logic [7:0] match_blue;
   logic [3:0] match_index;
   logic [4:0] entry_count;
   logic [1:0] status;

   modport source (output valid, match_red, match_green, match_blue, match_index,
                   entry_count, status, input ready);
   modport sink   (input valid, match_red, match_green, match_blue, match_index,
                   entry_count, status, output ready);
endinterface

>>> design/palette_nearest_color_match.sv
// An accepted request enters the first slot; its response is registered as it leaves the last.
// The request walks the whole slot chain, one slot per cycle while the chain is not held,
//   and the next one enters once it has retired.
// A stalled response holds the chain; new requests wait only until the one in flight retires.
// Reset clears the entry count and all in-flight requests; slot colors are not cleared.
// ----------------------------------------------------------------------------
// palette_nearest_color_match: ordered RGB palette with nearest-color lookup
// Append, remove-first-equal and squared-distance nearest match over a chain
// of palette slots.
// ----------------------------------------------------------------------------
module palette_nearest_color_match
   import pnc_pkg::*;
#(
   parameter int MAX_ENTRIES = PNC_MAX_ENTRIES
) (
   input logic      clock,
   input logic      reset,
   pnc_req_if.sink  req_ch,
   pnc_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] FULL_C = CNT_W'(MAX_ENTRIES);

   cell_bus_type     bus     [MAX_ENTRIES+1];
   logic [IDX_W-1:0] idx     [MAX_ENTRIES+1];
   logic [23:0]      entries [MAX_ENTRIES];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [23:0]      match_ff, match_in;
   logic [3:0]       index_ff, index_in;
   logic [1:0]       status_ff, status_in;
   logic [4:0]       rsp_count_ff;
   logic             accept;
   logic             retire;
   logic             advance;
   cell_bus_type     tail;

   // One request in flight at a time: the chain belongs to it until it retires.
   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && !busy_ff;

   // Launch the request into the first slot; the best-match fields start empty.
   always_comb begin
      bus[0]        = '0;
      bus[0].active = accept;
      bus[0].func   = req_ch.func;
      bus[0].color  = {req_ch.red, req_ch.green, req_ch.blue};
      idx[0]        = '0;
   end

   assign tail = bus[MAX_ENTRIES];

   // Retire the tail into the response register when that register is free;
   // otherwise hold the whole chain.
   assign retire  = tail.active && (!rsp_valid_ff || rsp_ch.ready);
   assign advance = !tail.active || retire;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_slot
      pnc_cell #(
         .MAX_ENTRIES (MAX_ENTRIES),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .count      (count_ff),
         .bus_in     (bus[i]),
         .idx_in     (idx[i]),
         .next_entry (entries[(i + 1 < MAX_ENTRIES) ? i + 1 : i]),
         .bus_out    (bus[i+1]),
         .idx_out    (idx[i+1]),
         .entry      (entries[i])
      );
   end

   // Resolve the count update and the response once the request leaves the chain.
   always_comb begin
      count_in  = count_ff;
      match_in  = '0;
      index_in  = '0;
      status_in = ST_OK;
      unique case (tail.func)
         FUNC_ADD: begin
            if (count_ff >= FULL_C) status_in = ST_FULL;
            else                    count_in  = count_ff + CNT_W'(1);
         end
         FUNC_REMOVE: begin
            if (tail.found) count_in  = count_ff - CNT_W'(1);
            else            status_in = ST_NOMATCH;
         end
         FUNC_QUERY: begin
            if (tail.have) begin
               match_in = tail.best_color;
               index_in = 4'(idx[MAX_ENTRIES]);
            end else begin
               status_in = ST_EMPTY;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (retire) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (accept) busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (retire) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (retire) begin
         match_ff     <= match_in;
         index_ff     <= index_in;
         status_ff    <= status_in;
         rsp_count_ff <= 5'(count_in);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.match_red   = match_ff[23:16];
   assign rsp_ch.match_green = match_ff[15:8];
   assign rsp_ch.match_blue  = match_ff[7:0];
   assign rsp_ch.match_index = index_ff;
   assign rsp_ch.entry_count = rsp_count_ff;
   assign rsp_ch.status      = status_ff;

endmodule

>>> design/pnc_cell.sv
// ----------------------------------------------------------------------------
// pnc_cell: one palette slot of the matcher chain
// Holds one color, acts on the passing request and hands it to the next slot.
// ----------------------------------------------------------------------------
module pnc_cell
   import pnc_pkg::*;
#(
   parameter int MAX_ENTRIES = PNC_MAX_ENTRIES,
   parameter int CELL_INDEX  = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0] count,
   input  cell_bus_type                     bus_in,
   input  logic [$clog2(MAX_ENTRIES)-1:0]   idx_in,
   input  logic [23:0]                      next_entry,
   output cell_bus_type                     bus_out,
   output logic [$clog2(MAX_ENTRIES)-1:0]   idx_out,
   output logic [23:0]                      entry
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] SLOT_C = CNT_W'(CELL_INDEX);
   localparam logic [IDX_W-1:0] SLOT_IDX_C = IDX_W'(CELL_INDEX);

   logic [23:0]       entry_ff, entry_in;
   cell_bus_type      bus_ff, bus_in_next;
   logic [IDX_W-1:0]  idx_ff, idx_in_next;
   logic              in_use;
   logic              hit;
   logic [DIST_W-1:0] cand_dist;

   assign in_use    = SLOT_C < count;
   assign hit       = in_use && (entry_ff == bus_in.color);
   assign cand_dist = color_dist_sq(bus_in.color, entry_ff);

   always_comb begin
      entry_in    = entry_ff;
      bus_in_next = bus_in;
      idx_in_next = idx_in;
      if (bus_in.active) begin
         unique case (bus_in.func)
            FUNC_ADD: begin
               if (count == SLOT_C) entry_in = bus_in.color;
            end
            FUNC_REMOVE: begin
               // close the gap: pull the neighbor's color once the match is seen
               if (in_use && (bus_in.found || hit)) begin
                  entry_in          = next_entry;
                  bus_in_next.found = 1'b1;
               end
            end
            FUNC_QUERY: begin
               // strict compare keeps the lowest index on a tie
               if (in_use && (!bus_in.have || cand_dist < bus_in.best_dist)) begin
                  bus_in_next.have       = 1'b1;
                  bus_in_next.best_dist  = cand_dist;
                  bus_in_next.best_color = entry_ff;
                  idx_in_next            = SLOT_IDX_C;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
         idx_ff   <= idx_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff <= '0;
      end else if (advance) begin
         bus_ff <= bus_in_next;
      end
   end

   assign bus_out = bus_ff;
   assign idx_out = idx_ff;
   assign entry   = entry_ff;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for palette_nearest_color_match
// Drives append, remove, query and unused-code requests, mirrors the palette
// in a shadow copy, and checks every response field against its prediction.
// ----------------------------------------------------------------------------
module tb;
   import pnc_pkg::*;

   // the unused function code: no operation, count reported unchanged
   localparam logic [1:0] FUNC_NOP = 2'd3;

   localparam int RANDOM_REQUESTS = 1525;
   localparam int QUIET_TAIL      = 150;
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [3:0] index;
      logic [4:0] count;
      logic [1:0] status;
   } match_reply_type;

   // Shadow palette: applies each accepted request in order and queues the
   // response it must produce.
   class palette_shadow;
      logic [23:0]     colors [PNC_MAX_ENTRIES];
      int unsigned     used;
      match_reply_type expected_matches [$];
      int unsigned     mismatches;

      function new();
         used       = 0;
         mismatches = 0;
      endfunction

      function int unsigned rgb_distance(logic [23:0] a, logic [23:0] b);
         int dr;
         int dg;
         int db;
         dr = int'(a[23:16]) - int'(b[23:16]);
         dg = int'(a[15:8]) - int'(b[15:8]);
         db = int'(a[7:0]) - int'(b[7:0]);
         return dr * dr + dg * dg + db * db;
      endfunction

      function void note_request(logic [1:0] func, logic [23:0] color);
         match_reply_type want;
         int              hit;
         int unsigned     best;
         int unsigned     cand_dist;
         want        = '0;
         want.status = ST_OK;
         case (func)
            FUNC_ADD: begin
               if (used >= PNC_MAX_ENTRIES) begin
                  want.status = ST_FULL;
               end else begin
                  colors[used] = color;
                  used++;
               end
            end
            FUNC_REMOVE: begin
               hit = -1;
               for (int i = 0; i < used; i++) begin
                  if (hit < 0 && colors[i] == color) hit = i;
               end
               if (hit < 0) begin
                  want.status = ST_NOMATCH;
               end else begin
                  // close the gap: later entries move down one slot
                  for (int i = hit; i + 1 < used; i++) colors[i] = colors[i + 1];
                  used--;
               end
            end
            FUNC_QUERY: begin
               if (used == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  best = rgb_distance(color, colors[0]);
                  hit  = 0;
                  // strict compare keeps the lowest index on a tie
                  for (int i = 1; i < used; i++) begin
                     cand_dist = rgb_distance(color, colors[i]);
                     if (cand_dist < best) begin
                        best = cand_dist;
                        hit  = i;
                     end
                  end
                  {want.red, want.green, want.blue} = colors[hit];
                  want.index = 4'(hit);
               end
            end
            default: ;
         endcase
         want.count = 5'(used);
         expected_matches.insert(expected_matches.size(), want);
      endfunction

      function void compare_field(string field, int want_v, int got_v);
         if (want_v != got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
         end
      endfunction

      function void check_reply(match_reply_type got);
         match_reply_type want;
         if (expected_matches.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = expected_matches.pop_front();
         compare_field("match_red",   want.red,    got.red);
         compare_field("match_green", want.green,  got.green);
         compare_field("match_blue",  want.blue,   got.blue);
         compare_field("match_index", want.index,  got.index);
         compare_field("entry_count", want.count,  got.count);
         compare_field("status",      want.status, got.status);
      endfunction
   endclass

   logic clock;
   logic reset;

   pnc_req_if req_bus ();
   pnc_rsp_if rsp_bus ();

   palette_nearest_color_match dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   palette_shadow shadow = new();

   // set near the end of the run: both sides stop idling
   bit quiet_tail = 1'b0;
   // requests left in the current no-gap stretch on the send side
   int send_calm  = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Favor the extremes of a channel now and then.
   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 9))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hff;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic logic [23:0] rand_color();
      return {rand_channel(), rand_channel(), rand_channel()};
   endfunction

   function automatic logic [23:0] existing_color();
      return shadow.colors[$urandom_range(0, shadow.used - 1)];
   endfunction

   // Pick the idle gap before the next request: random idle gaps, broken up
   // by stretches with no gaps at all.
   function automatic int next_send_gap();
      if (quiet_tail) return 0;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) begin
         send_calm = $urandom_range(5, 30);
         return 0;
      end
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 10);
      return 0;
   endfunction

   // Offer one request and hold it until the block takes it, then record it.
   task automatic send_request(input logic [1:0] func, input logic [23:0] color);
      int gap;
      gap = next_send_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.red   <= color[23:16];
      req_bus.green <= color[15:8];
      req_bus.blue  <= color[7:0];
      do @(posedge clock); while (!req_bus.ready);
      shadow.note_request(func, color);
   endtask

   // Directed requests: empty palette, every code, ties, shifts, full palette.
   task automatic run_directed();
      send_request(FUNC_QUERY,  24'h000000);   // query on an empty palette
      send_request(FUNC_REMOVE, 24'h000000);   // remove from an empty palette
      send_request(FUNC_NOP,    24'hffffff);   // unused code, nothing changes
      send_request(FUNC_ADD,    24'h000000);
      send_request(FUNC_ADD,    24'hffffff);
      send_request(FUNC_ADD,    24'h808080);
      send_request(FUNC_ADD,    24'h000000);   // duplicate of entry 0
      send_request(FUNC_QUERY,  24'h404040);   // equal distance to 0 and 2: lowest wins
      send_request(FUNC_QUERY,  24'hff00ff);
      send_request(FUNC_REMOVE, 24'h000000);   // first equal goes, rest shift down
      send_request(FUNC_REMOVE, 24'h123456);   // no equal entry
      send_request(FUNC_QUERY,  24'h000000);   // hits the former duplicate
      send_request(FUNC_NOP,    24'h000000);
      // fill the palette to the top
      while (shadow.used < PNC_MAX_ENTRIES)
         send_request(FUNC_ADD, {8'(shadow.used * 17), 8'(255 - shadow.used * 16),
                                 8'(shadow.used * 5)});
      send_request(FUNC_ADD,    24'hffffff);   // full: dropped
      send_request(FUNC_QUERY,  24'hff0000);
      send_request(FUNC_REMOVE, shadow.colors[PNC_MAX_ENTRIES - 1]);   // last slot
      send_request(FUNC_QUERY,  24'h00ff00);
   endtask

   // Random requests: mostly queries on a palette that swings between
   // filling and draining, so both the full and the empty case come back.
   task automatic run_random(input int total);
      int          pick;
      bit          draining;
      logic [1:0]  func;
      logic [23:0] color;
      draining = 1'b0;
      for (int k = 0; k < total; k++) begin
         if (k >= total - QUIET_TAIL) quiet_tail = 1'b1;
         if (shadow.used == PNC_MAX_ENTRIES && $urandom_range(0, 3) == 0) draining = 1'b1;
         if (shadow.used == 0) draining = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 2)       func = FUNC_NOP;
         else if (pick < 22) func = draining ? FUNC_REMOVE : FUNC_ADD;
         else if (pick < 28) func = draining ? FUNC_ADD : FUNC_REMOVE;
         else                func = FUNC_QUERY;
         color = rand_color();
         if (shadow.used > 0) begin
            case (func)
               FUNC_REMOVE: begin
                  if ($urandom_range(0, 4) != 0) color = existing_color();
               end
               FUNC_ADD: begin
                  if ($urandom_range(0, 7) == 0) color = existing_color();
               end
               FUNC_QUERY: begin
                  if ($urandom_range(0, 5) == 0) color = existing_color();
               end
               default: ;
            endcase
         end
         send_request(func, color);
      end
   endtask

   // Stimulus and end of run.
   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.func  <= FUNC_ADD;
      req_bus.red   <= 8'h00;
      req_bus.green <= 8'h00;
      req_bus.blue  <= 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(RANDOM_REQUESTS);
      req_bus.valid <= 1'b0;

      // drain what is in flight, then give a stray response time to show up
      while (shadow.expected_matches.size() != 0) @(posedge clock);
      repeat (PNC_MAX_ENTRIES + 6) @(posedge clock);

      if (shadow.mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Response side: check each accepted response, stall in random bursts,
   // and once hold off long enough to back the block up into its input.
   initial begin
      match_reply_type got;
      int              stall_left;
      int              calm_left;
      int              replies;
      bit              held_off;
      stall_left = 0;
      calm_left  = 0;
      replies    = 0;
      held_off   = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.match_red, rsp_bus.match_green, rsp_bus.match_blue,
                   rsp_bus.match_index, rsp_bus.entry_count, rsp_bus.status};
            shadow.check_reply(got);
            replies++;
         end
         if (!held_off && replies == HOLD_OFF_AT) begin
            held_off   = 1'b1;
            stall_left = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (quiet_tail || calm_left > 0) begin
            if (calm_left > 0) calm_left--;
            rsp_bus.ready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            // start a stall of random length in this cycle
            stall_left = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(20, 120);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when neither channel moves for too long.
   initial begin
      int still;
      still = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            still = 0;
         else
            still++;
         if (still >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no request or response moved", $time);
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule

>>> palette_nearest_color_match.f
design/pnc_pkg.sv
design/pnc_if.sv
design/pnc_cell.sv
design/palette_nearest_color_match.sv
sim/tb.sv
